### hdl/rcs_pkg.sv
// Shared constants, types and codes of the raycaster column pixel shader.
package rcs_pkg;

    localparam int TEX_SIZE       = 64;
    localparam int SCREEN_ROWS    = 512;
    localparam int SCREEN_COLUMNS = 1024;

    localparam int TEX_AW    = $clog2(TEX_SIZE);
    localparam int TEX_DEPTH = TEX_SIZE * TEX_SIZE;
    localparam int ADDR_W    = 2 * TEX_AW;
    localparam int HALF_ROWS = SCREEN_ROWS / 2;
    localparam int ROW_SH    = $clog2(HALF_ROWS);
    localparam int FRAC_SH   = 16 - TEX_AW;

    // divider operand widths
    localparam int NUM_W = 24;
    localparam int DEN_W = 16;

    // floor(H*65536/(15*D)) == floor(DIM_NUM / k) with D = 2k
    localparam int DIM_NUM = HALF_ROWS * 65536 / 15;

    localparam logic [31:0] SKY_COLOR      = 32'h0087CEEB;
    localparam logic [31:0] WALL_FALLBACK  = 32'h00654321;
    localparam logic [31:0] DOOR_FALLBACK  = 32'h00FF0000;
    localparam logic [31:0] FLOOR_FALLBACK = 32'h00228B22;

    localparam logic [1:0] SURF_WALL  = 2'd0;
    localparam logic [1:0] SURF_DOOR  = 2'd1;
    localparam logic [1:0] SURF_FLOOR = 2'd2;
    localparam logic [1:0] SURF_NONE  = 2'd3;

    localparam logic REQ_LOAD = 1'b0;

    typedef enum logic [2:0] {
        K_DROP,
        K_LOAD,
        K_COLOR,
        K_WALL,
        K_DOOR,
        K_FLOOR
    } kind_t;

    // fields that ride alongside the dividers
    typedef struct packed {
        kind_t              kind;
        logic [1:0]         surface;
        logic [8:0]         row;
        logic [9:0]         column;
        logic [31:0]        word;
        logic               num_neg;
        logic               cos_neg;
        logic               sin_neg;
        logic signed [31:0] px;
        logic signed [31:0] py;
    } side_t;

    typedef struct packed {
        side_t              side;
        logic [NUM_W-1:0]   n_span;
        logic [NUM_W-1:0]   n_x;
        logic [NUM_W-1:0]   n_y;
        logic [DEN_W-1:0]   den;
    } item_t;

    // resolved texel access after the divide
    typedef struct packed {
        kind_t              kind;
        logic [1:0]         surface;
        logic [8:0]         row;
        logic [9:0]         column;
        logic [31:0]        word;
        logic               ok;
        logic [ADDR_W-1:0]  addr;
        logic [15:0]        dim;
    } stg_t;

endpackage

### hdl/rcs_req_if.sv
// Request channel: texel loads and pixel render requests.
interface rcs_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [1:0]         surface;
    logic [8:0]         row;
    logic [9:0]         column;
    logic [31:0]        texel;
    logic signed [15:0] span_start;
    logic signed [15:0] span_end;
    logic [15:0]        wall_height;
    logic signed [15:0] ray_cos;
    logic signed [15:0] ray_sin;
    logic signed [31:0] player_x;
    logic signed [31:0] player_y;

    modport source (
        output valid, req_type, surface, row, column, texel, span_start, span_end,
               wall_height, ray_cos, ray_sin, player_x, player_y,
        input  ready
    );
    modport sink (
        input  valid, req_type, surface, row, column, texel, span_start, span_end,
               wall_height, ray_cos, ray_sin, player_x, player_y,
        output ready
    );
endinterface

### hdl/rcs_pix_if.sv
// Pixel channel toward the frame buffer.
interface rcs_pix_if;
    logic        valid;
    logic        ready;
    logic [8:0]  pixel_row;
    logic [9:0]  pixel_column;
    logic [31:0] pixel_color;

    modport source (
        output valid, pixel_row, pixel_column, pixel_color,
        input  ready
    );
    modport sink (
        input  valid, pixel_row, pixel_column, pixel_color,
        output ready
    );
endinterface

### hdl/rcs_front.sv
// Front end: accepts request words and classifies them into queue items.
module rcs_front (
    rcs_req_if.sink         req,
    input  logic            full,
    output logic            push,
    output rcs_pkg::item_t  item
);

    assign req.ready = !full;
    assign push      = req.valid && !full;

    always_comb
    begin
        logic signed [17:0] y_s;
        logic signed [17:0] start_s;
        logic signed [17:0] end_s;
        logic signed [17:0] wall_s;
        logic [17:0]        wall_mag;
        logic signed [17:0] door_s;
        logic [11:0]        k;
        logic [15:0]        cos_mag;
        logic [15:0]        sin_mag;

        y_s      = $signed({9'b0, req.row});
        start_s  = {{2{req.span_start[15]}}, req.span_start};
        end_s    = {{2{req.span_end[15]}}, req.span_end};
        wall_s   = y_s - $signed(18'(rcs_pkg::HALF_ROWS))
                 + $signed({3'b0, req.wall_height[15:1]});
        wall_mag = wall_s[17] ? 18'(-wall_s) : 18'(wall_s);
        door_s   = y_s - start_s;
        k        = 12'(req.row) - 12'(rcs_pkg::HALF_ROWS);
        cos_mag  = req.ray_cos[15] ? 16'(-req.ray_cos) : 16'(req.ray_cos);
        sin_mag  = req.ray_sin[15] ? 16'(-req.ray_sin) : 16'(req.ray_sin);

        item              = '0;
        item.side.kind    = rcs_pkg::K_DROP;
        item.side.surface = req.surface;
        item.side.row     = req.row;
        item.side.column  = req.column;
        item.side.px      = req.player_x;
        item.side.py      = req.player_y;
        item.side.cos_neg = req.ray_cos[15];
        item.side.sin_neg = req.ray_sin[15];

        if (req.req_type == rcs_pkg::REQ_LOAD)
        begin
            if (int'(req.row) < rcs_pkg::TEX_SIZE && int'(req.column) < rcs_pkg::TEX_SIZE
                && req.surface != rcs_pkg::SURF_NONE)
            begin
                item.side.kind = rcs_pkg::K_LOAD;
                item.side.word = req.texel;
            end
        end
        else if (int'(req.row) < rcs_pkg::SCREEN_ROWS
                 && int'(req.column) < rcs_pkg::SCREEN_COLUMNS)
        begin
            if (y_s < start_s)
            begin
                item.side.kind = rcs_pkg::K_COLOR;
                item.side.word = rcs_pkg::SKY_COLOR;
            end
            else if (y_s <= end_s)
            begin
                item.den = req.wall_height;
                if (req.wall_height == '0)
                begin
                    item.side.kind = rcs_pkg::K_COLOR;
                    item.side.word = (req.surface == rcs_pkg::SURF_DOOR)
                                   ? rcs_pkg::DOOR_FALLBACK : rcs_pkg::WALL_FALLBACK;
                end
                else if (req.surface == rcs_pkg::SURF_DOOR)
                begin
                    item.side.kind = rcs_pkg::K_DOOR;
                    item.n_span    = rcs_pkg::NUM_W'(door_s[16:0]) << rcs_pkg::TEX_AW;
                end
                else
                begin
                    item.side.kind    = rcs_pkg::K_WALL;
                    item.side.num_neg = wall_s[17];
                    item.n_span       = rcs_pkg::NUM_W'(wall_mag[16:0]) << rcs_pkg::TEX_AW;
                end
            end
            else if (int'(req.row) > rcs_pkg::HALF_ROWS)
            begin
                item.side.kind = rcs_pkg::K_FLOOR;
                item.den       = rcs_pkg::DEN_W'(k);
                item.n_x       = rcs_pkg::NUM_W'(cos_mag) << rcs_pkg::ROW_SH;
                item.n_y       = rcs_pkg::NUM_W'(sin_mag) << rcs_pkg::ROW_SH;
            end
            else
            begin
                item.side.kind = rcs_pkg::K_COLOR;
                item.side.word = rcs_pkg::FLOOR_FALLBACK;
            end
        end
    end

endmodule

### hdl/rcs_queue.sv
// Two-entry queue between the front end and the shading pipeline.
module rcs_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rcs_pkg::item_t  push_item,
    input  logic            pop,
    output logic            full,
    output logic            avail,
    output rcs_pkg::item_t  head
);

    rcs_pkg::item_t mem_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     cnt_reg;
    logic [1:0]     cnt_next;

    assign full  = (cnt_reg == 2'd2);
    assign avail = (cnt_reg != 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### hdl/rcs_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module rcs_div (
    input  logic                        clk,
    input  logic                        adv,
    input  logic [rcs_pkg::NUM_W-1:0]   num,
    input  logic [rcs_pkg::DEN_W-1:0]   den,
    output logic [rcs_pkg::NUM_W-1:0]   quot
);

    localparam int NW = rcs_pkg::NUM_W;
    localparam int DW = rcs_pkg::DEN_W;

    logic [DW-1:0] rem_reg [NW];
    logic [NW-1:0] nq_reg  [NW];
    logic [DW-1:0] den_reg [NW];

    for (genvar s = 0; s < NW; s++)
    begin : g_stage
        logic [DW-1:0] rem_in;
        logic [NW-1:0] nq_in;
        logic [DW-1:0] den_in;
        logic [DW:0]   shifted;
        logic [DW:0]   diff;
        logic          ge;
        logic [DW-1:0] rem_next;
        logic [NW-1:0] nq_next;

        if (s == 0)
        begin : g_first
            assign rem_in = '0;
            assign nq_in  = num;
            assign den_in = den;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign nq_in  = nq_reg[s-1];
            assign den_in = den_reg[s-1];
        end

        always_comb
        begin
            shifted  = {rem_in, nq_in[NW-1]};
            diff     = shifted - {1'b0, den_in};
            ge       = (shifted >= {1'b0, den_in});
            rem_next = ge ? diff[DW-1:0] : shifted[DW-1:0];
            nq_next  = {nq_in[NW-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[s] <= rem_next;
                nq_reg[s]  <= nq_next;
                den_reg[s] <= den_in;
            end
        end
    end

    assign quot = nq_reg[NW-1];

endmodule

### hdl/rcs_back.sv
// Shading pipeline: divides, texel lookup, dimming and the output register.
module rcs_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            avail,
    input  rcs_pkg::item_t  head,
    output logic            pop,
    rcs_pix_if.source       pix
);

    localparam int NW = rcs_pkg::NUM_W;
    localparam int AW = rcs_pkg::TEX_AW;

    logic                       adv;
    logic [NW-1:0]              q_span;
    logic [NW-1:0]              q_x;
    logic [NW-1:0]              q_y;
    logic [NW-1:0]              q_dim;

    rcs_pkg::side_t             side_reg [NW];
    logic                       vld_reg  [NW];

    rcs_pkg::stg_t              p_next;
    rcs_pkg::stg_t              p_reg;
    logic                       p_vld_reg;
    rcs_pkg::stg_t              m_reg;
    logic                       m_vld_reg;
    logic [2:0]                 present_reg;

    logic [31:0]                wall_mem  [rcs_pkg::TEX_DEPTH];
    logic [31:0]                door_mem  [rcs_pkg::TEX_DEPTH];
    logic [31:0]                floor_mem [rcs_pkg::TEX_DEPTH];
    logic [31:0]                wall_rd_reg;
    logic [31:0]                door_rd_reg;
    logic [31:0]                floor_rd_reg;

    logic                       out_valid_reg;
    logic [8:0]                 out_row_reg;
    logic [9:0]                 out_column_reg;
    logic [31:0]                out_color_reg;
    logic [31:0]                color_next;
    logic                       emit_next;

    assign adv = !out_valid_reg || pix.ready;
    assign pop = adv && avail;

    rcs_div u_div_span (.clk(clk), .adv(adv), .num(head.n_span), .den(head.den),
                        .quot(q_span));
    rcs_div u_div_x    (.clk(clk), .adv(adv), .num(head.n_x), .den(head.den),
                        .quot(q_x));
    rcs_div u_div_y    (.clk(clk), .adv(adv), .num(head.n_y), .den(head.den),
                        .quot(q_y));
    rcs_div u_div_dim  (.clk(clk), .adv(adv), .num(NW'(rcs_pkg::DIM_NUM)),
                        .den(head.den), .quot(q_dim));

    // Hold item fields in step with the divider stages.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= head.side;
            for (int i = 1; i < NW; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NW; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            p_vld_reg     <= 1'b0;
            m_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            present_reg   <= '0;
        end
        else if (adv)
        begin
            vld_reg[0] <= pop;
            for (int i = 1; i < NW; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
            p_vld_reg     <= vld_reg[NW-1];
            m_vld_reg     <= p_vld_reg;
            out_valid_reg <= emit_next;
            if (p_vld_reg && p_reg.kind == rcs_pkg::K_LOAD)
            begin
                present_reg[p_reg.surface] <= 1'b1;
            end
        end
    end

    // Floor coordinate: trunc(pos*T/65536) rem T; negative remainders fall back.
    function automatic logic [AW:0] floor_coord(input logic signed [33:0] pos);
        logic [33:0]   mag;
        logic [AW-1:0] c;
        logic          ok;
        mag = 34'(-pos);
        if (!pos[33])
        begin
            ok = 1'b1;
            c  = pos[15:rcs_pkg::FRAC_SH];
        end
        else
        begin
            ok = (mag[15:rcs_pkg::FRAC_SH] == '0);
            c  = '0;
        end
        return {ok, c};
    endfunction

    always_comb
    begin
        rcs_pkg::side_t     s;
        logic signed [33:0] off_x;
        logic signed [33:0] off_y;
        logic signed [33:0] pos_x;
        logic signed [33:0] pos_y;
        logic [AW:0]        cx;
        logic [AW:0]        cy;
        logic [16:0]        dim_w;

        s     = side_reg[NW-1];
        off_x = s.cos_neg ? -$signed({10'b0, q_x}) : $signed({10'b0, q_x});
        off_y = s.sin_neg ? -$signed({10'b0, q_y}) : $signed({10'b0, q_y});
        pos_x = {{2{s.px[31]}}, s.px} + off_x;
        pos_y = {{2{s.py[31]}}, s.py} + off_y;
        cx    = floor_coord(pos_x);
        cy    = floor_coord(pos_y);
        dim_w = 17'h10000 - q_dim[16:0];

        p_next.kind    = s.kind;
        p_next.surface = s.surface;
        p_next.row     = s.row;
        p_next.column  = s.column;
        p_next.word    = s.word;
        p_next.ok      = 1'b0;
        p_next.addr    = '0;
        if (q_dim[NW-1:16] != '0)
        begin
            p_next.dim = '0;
        end
        else if (q_dim == '0)
        begin
            p_next.dim = 16'hFFFF;
        end
        else
        begin
            p_next.dim = dim_w[15:0];
        end

        case (s.kind)
            rcs_pkg::K_WALL:
            begin
                p_next.ok   = s.num_neg ? (q_span == '0)
                                        : (q_span < NW'(rcs_pkg::TEX_SIZE));
                p_next.addr = {q_span[AW-1:0], s.column[AW-1:0]};
            end
            rcs_pkg::K_DOOR:
            begin
                p_next.ok   = (q_span < NW'(rcs_pkg::TEX_SIZE));
                p_next.addr = {q_span[AW-1:0], s.column[AW-1:0]};
            end
            rcs_pkg::K_FLOOR:
            begin
                p_next.ok   = cx[AW] && cy[AW];
                p_next.addr = {cy[AW-1:0], cx[AW-1:0]};
            end
            rcs_pkg::K_LOAD:
            begin
                p_next.addr = {s.row[AW-1:0], s.column[AW-1:0]};
            end
            default:
            begin
                p_next.ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg <= p_next;
            m_reg <= p_reg;
            case (p_reg.kind)
                rcs_pkg::K_WALL:  m_reg.ok <= p_reg.ok && present_reg[0];
                rcs_pkg::K_DOOR:  m_reg.ok <= p_reg.ok && present_reg[1];
                rcs_pkg::K_FLOOR: m_reg.ok <= p_reg.ok && present_reg[2];
                default:          m_reg.ok <= 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (p_vld_reg && p_reg.kind == rcs_pkg::K_LOAD
                && p_reg.surface == rcs_pkg::SURF_WALL)
            begin
                wall_mem[p_reg.addr] <= p_reg.word;
            end
            wall_rd_reg <= wall_mem[p_reg.addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (p_vld_reg && p_reg.kind == rcs_pkg::K_LOAD
                && p_reg.surface == rcs_pkg::SURF_DOOR)
            begin
                door_mem[p_reg.addr] <= p_reg.word;
            end
            door_rd_reg <= door_mem[p_reg.addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (p_vld_reg && p_reg.kind == rcs_pkg::K_LOAD
                && p_reg.surface == rcs_pkg::SURF_FLOOR)
            begin
                floor_mem[p_reg.addr] <= p_reg.word;
            end
            floor_rd_reg <= floor_mem[p_reg.addr];
        end
    end

    always_comb
    begin
        logic [23:0] r_p;
        logic [23:0] g_p;
        logic [23:0] b_p;

        r_p = floor_rd_reg[23:16] * m_reg.dim;
        g_p = floor_rd_reg[15:8] * m_reg.dim;
        b_p = floor_rd_reg[7:0] * m_reg.dim;

        emit_next = 1'b0;
        case (m_reg.kind)
            rcs_pkg::K_COLOR:
            begin
                emit_next  = m_vld_reg;
                color_next = m_reg.word;
            end
            rcs_pkg::K_WALL:
            begin
                emit_next  = m_vld_reg;
                color_next = m_reg.ok ? wall_rd_reg : rcs_pkg::WALL_FALLBACK;
            end
            rcs_pkg::K_DOOR:
            begin
                emit_next  = m_vld_reg;
                color_next = m_reg.ok ? door_rd_reg : rcs_pkg::DOOR_FALLBACK;
            end
            rcs_pkg::K_FLOOR:
            begin
                emit_next  = m_vld_reg;
                color_next = m_reg.ok ? {8'h00, r_p[23:16], g_p[23:16], b_p[23:16]}
                                      : rcs_pkg::FLOOR_FALLBACK;
            end
            default:
            begin
                color_next = m_reg.word;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_row_reg    <= m_reg.row;
            out_column_reg <= m_reg.column;
            out_color_reg  <= color_next;
        end
    end

    assign pix.valid        = out_valid_reg;
    assign pix.pixel_row    = out_row_reg;
    assign pix.pixel_column = out_column_reg;
    assign pix.pixel_color  = out_color_reg;

endmodule

### hdl/raycast_column_pixel_shader.sv
// Raycaster column pixel shader: top level.
//
// The req channel carries two kinds of word. A load word writes one texel of
// the wall, door or floor texture and marks that texture present; it yields
// no pixel. A render word names one screen pixel with its column's wall span,
// wall height, ray direction and player position; it yields one pixel word
// on the pix channel: sky above the span, a wall or door texel inside it, or
// a distance-dimmed floor texel below it. Off-screen renders and loads that
// fall outside the texture are dropped.
// Words are taken one per clock while req.ready is high. The depth of the
// pipeline is set by the 24-stage pipelined divider, one quotient bit per
// stage, plus address, texture read and shade stages. Results leave in
// request order.
// When pix stalls, the whole shading pipeline holds and the two-entry queue
// behind the front end fills; req.ready drops once it is full.
// Reset clears the pipeline, the queue and the texture-present flags; texture
// contents stay undefined until loaded.
module raycast_column_pixel_shader (
    input  logic      clk,
    input  logic      rst_n,
    rcs_req_if.sink   req,
    rcs_pix_if.source pix
);

    logic           full;
    logic           push;
    logic           pop;
    logic           avail;
    rcs_pkg::item_t push_item;
    rcs_pkg::item_t head;

    rcs_front u_front (
        .req  (req),
        .full (full),
        .push (push),
        .item (push_item)
    );

    rcs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (full),
        .avail     (avail),
        .head      (head)
    );

    rcs_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .avail (avail),
        .head  (head),
        .pop   (pop),
        .pix   (pix)
    );

endmodule

### hdl/rcs_checker.sv
// Port-level checks of the shader and their binding to the top level.
module rcs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        pix_valid,
    input logic        pix_ready,
    input logic [8:0]  pix_row,
    input logic [9:0]  pix_column,
    input logic [31:0] pix_color
);

    // A stalled pixel word stays put.
    a_pix_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_ready |=> pix_valid && $stable(pix_row)
            && $stable(pix_column) && $stable(pix_color))
        else $error("pixel word changed while stalled");

    // The queue only fills on an accepted word.
    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(req_ready) |-> $past(req_valid && req_ready))
        else $error("req.ready dropped without an accepted word");

    // With the sink open the pipeline drains one queue entry per cycle.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready && pix_ready |=> req_ready)
        else $error("queue stayed full while pix was ready");

endmodule

bind raycast_column_pixel_shader rcs_checker u_rcs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .pix_valid  (pix.valid),
    .pix_ready  (pix.ready),
    .pix_row    (pix.pixel_row),
    .pix_column (pix.pixel_column),
    .pix_color  (pix.pixel_color)
);

### tb/rcs_tb_if.sv
`timescale 1ns / 100ps
// Test-side notes: the block's own interfaces are reused; this file holds shared tb types.
package rcs_tb_pkg;

    typedef struct {
        logic [8:0]  row;
        logic [9:0]  column;
        logic [31:0] color;
    } pixel_exp_t;

endpackage

### tb/raycast_column_pixel_shader_checker.sv
`timescale 1ns / 100ps
// Checker: watches both channels, predicts each pixel and compares it.
module raycast_column_pixel_shader_checker
    import rcs_pkg::*;
    import rcs_tb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    rcs_req_if      req,
    rcs_pix_if      pix,
    output int      fail_count,
    output int      pending
);

    logic [31:0] wall_mem  [TEX_DEPTH];
    logic [31:0] door_mem  [TEX_DEPTH];
    logic [31:0] floor_mem [TEX_DEPTH];
    logic [2:0]  present;
    pixel_exp_t  pixel_q [$];

    assign pending = pixel_q.size();

    function automatic logic [31:0] tex_pick(logic [31:0] t, longint ty, longint tx,
                                             logic have, logic [31:0] fb);
        if (ty < 0 || ty >= TEX_SIZE || tx < 0 || tx >= TEX_SIZE || !have)
            return fb;
        return t;
    endfunction

    function automatic longint floor_coord(longint p, longint trig, longint d);
        longint pos;
        pos = p + (longint'(SCREEN_ROWS) * trig) / d;
        return ((pos * TEX_SIZE) / 65536) % TEX_SIZE;
    endfunction

    function automatic logic [31:0] shade_floor(longint y, longint c, longint s,
                                                longint px, longint py);
        longint d, tx, ty, dim;
        logic [31:0] base;
        logic [7:0]  r, g, b;
        d = 2 * y - SCREEN_ROWS;
        if (d <= 0)
            return FLOOR_FALLBACK;
        tx = floor_coord(px, c, d);
        ty = floor_coord(py, s, d);
        if (tx < 0 || tx >= TEX_SIZE || ty < 0 || ty >= TEX_SIZE || !present[2])
            return FLOOR_FALLBACK;
        dim = 65536 - (longint'(SCREEN_ROWS) * 65536) / (15 * d);
        if (dim < 0)
            dim = 0;
        if (dim > 65535)
            dim = 65535;
        base = floor_mem[ty * TEX_SIZE + tx];
        r = (longint'(base[23:16]) * dim) >> 16;
        g = (longint'(base[15:8]) * dim) >> 16;
        b = (longint'(base[7:0]) * dim) >> 16;
        return {8'h00, r, g, b};
    endfunction

    function automatic logic [31:0] shade_pixel();
        longint y, st, en, wh, tx, ty;
        y  = req.row;
        st = req.span_start;
        en = req.span_end;
        wh = req.wall_height;
        tx = req.column % TEX_SIZE;
        if (y < st)
            return SKY_COLOR;
        if (y > en)
            return shade_floor(y, req.ray_cos, req.ray_sin, req.player_x, req.player_y);
        if (req.surface == SURF_DOOR)
        begin
            if (wh == 0)
                return DOOR_FALLBACK;
            ty = ((y - st) * TEX_SIZE) / wh;
            if (ty < 0 || ty >= TEX_SIZE || !present[1])
                return DOOR_FALLBACK;
            return tex_pick(door_mem[ty * TEX_SIZE + tx], ty, tx, 1'b1, DOOR_FALLBACK);
        end
        if (wh == 0)
            return WALL_FALLBACK;
        ty = ((y - HALF_ROWS + wh / 2) * TEX_SIZE) / wh;
        if (ty < 0 || ty >= TEX_SIZE || !present[0])
            return WALL_FALLBACK;
        return tex_pick(wall_mem[ty * TEX_SIZE + tx], ty, tx, 1'b1, WALL_FALLBACK);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_exp_t e;
        int idx;
        if (!rst_n)
        begin
            present    <= '0;
            fail_count <= 0;
            pixel_q.delete();
        end
        else
        begin
            if (pix.valid && pix.ready)
            begin
                if (pixel_q.size() == 0)
                begin
                    $error("pixel word with none expected: row %0d column %0d",
                           pix.pixel_row, pix.pixel_column);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = pixel_q.pop_front();
                    if (pix.pixel_row !== e.row)
                    begin
                        $error("pixel_row expected %0d actual %0d", e.row, pix.pixel_row);
                        fail_count <= fail_count + 1;
                    end
                    if (pix.pixel_column !== e.column)
                    begin
                        $error("pixel_column expected %0d actual %0d",
                               e.column, pix.pixel_column);
                        fail_count <= fail_count + 1;
                    end
                    if (pix.pixel_color !== e.color)
                    begin
                        $error("pixel_color expected %h actual %h", e.color, pix.pixel_color);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                if (req.req_type == REQ_LOAD)
                begin
                    idx = req.row * TEX_SIZE + req.column;
                    if (req.row < TEX_SIZE && req.column < TEX_SIZE && req.surface != SURF_NONE)
                    begin
                        case (req.surface)
                            SURF_WALL: wall_mem[idx]  = req.texel;
                            SURF_DOOR: door_mem[idx]  = req.texel;
                            default:   floor_mem[idx] = req.texel;
                        endcase
                        present[req.surface] <= 1'b1;
                    end
                end
                else if (req.row < SCREEN_ROWS && req.column < SCREEN_COLUMNS)
                begin
                    e.row    = req.row;
                    e.column = req.column;
                    e.color  = shade_pixel();
                    pixel_q.push_back(e);
                end
            end
        end
    end

endmodule

### tb/raycast_column_pixel_shader_test.sv
`timescale 1ns / 100ps
// Testbench top: clock, reset, stimulus, receiver stalls and verdict.
module raycast_column_pixel_shader_test;
    import rcs_pkg::*;

    localparam int WATCHDOG = 20000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   send_idle;
    int   recv_stall;
    bit   hold_off;
    int   quiet;
    bit   timed_out;

    rcs_req_if req ();
    rcs_pix_if pix ();

    raycast_column_pixel_shader u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .pix   (pix.source)
    );

    raycast_column_pixel_shader_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .pix        (pix),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // receiver side
    always @(posedge clk)
    begin
        if (hold_off)
            pix.ready <= 1'b0;
        else
            pix.ready <= ($urandom_range(99) >= recv_stall);
    end

    // watchdog on accepted words
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (pix.valid && pix.ready) || !rst_n)
            quiet <= 0;
        else
            quiet <= quiet + 1;
    end

    always @(posedge clk)
    begin
        if (quiet >= WATCHDOG)
        begin
            $display("watchdog expired");
            $display("Test completed with failures");
            $finish;
        end
    end

    // one word; loads only target written-safe textures as asked by caller
    task automatic send_word(logic rt, logic [1:0] surf, logic [8:0] r, logic [9:0] c,
                             logic [31:0] tex, logic signed [15:0] st,
                             logic signed [15:0] en, logic [15:0] wh,
                             logic signed [15:0] rc, logic signed [15:0] rs,
                             logic signed [31:0] px, logic signed [31:0] py);
        while ($urandom_range(99) < send_idle)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.req_type    <= rt;
        req.surface     <= surf;
        req.row         <= r;
        req.column      <= c;
        req.texel       <= tex;
        req.span_start  <= st;
        req.span_end    <= en;
        req.wall_height <= wh;
        req.ray_cos     <= rc;
        req.ray_sin     <= rs;
        req.player_x    <= px;
        req.player_y    <= py;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    task automatic idle_one();
        req.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_tex(logic [1:0] surf, logic [8:0] r, logic [9:0] c, logic [31:0] t);
        send_word(REQ_LOAD, surf, r, c, t, 0, 0, 1, 0, 0, 0, 0);
    endtask

    // fill a whole texture so no render can touch an unwritten texel
    task automatic fill_tex(logic [1:0] surf);
        for (int i = 0; i < TEX_SIZE * TEX_SIZE; i++)
            load_tex(surf, i / TEX_SIZE, i % TEX_SIZE, $urandom());
    endtask

    function automatic logic signed [15:0] rand_trig();
        case ($urandom_range(3))
            0: return 16'sd16384;
            1: return -16'sd16384;
            default: return $signed(16'($urandom_range(32768))) - 16'sd16384;
        endcase
    endfunction

    task automatic rand_render(bit wild);
        logic [8:0]  r;
        logic [15:0] wh;
        logic signed [15:0] st, en;
        logic signed [31:0] px, py;
        r  = $urandom_range(511);
        wh = wild ? 16'($urandom()) : 16'($urandom_range(1, 700));
        st = wild ? 16'($urandom()) : $signed(16'(HALF_ROWS)) - $signed(16'(wh / 2));
        en = wild ? 16'($urandom()) : st + $signed(wh) - 16'sd1;
        px = wild ? 32'($urandom()) : 32'($urandom_range(64 * 65536));
        py = wild ? 32'($urandom()) : 32'($urandom_range(64 * 65536));
        send_word(1'b1, 2'($urandom()), r, 10'($urandom()), $urandom(), st, en, wh,
                  rand_trig(), rand_trig(), px, py);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    initial
    begin
        req.valid       = 1'b0;
        req.req_type    = 1'b0;
        req.surface     = '0;
        req.row         = '0;
        req.column      = '0;
        req.texel       = '0;
        req.span_start  = '0;
        req.span_end    = '0;
        req.wall_height = 16'd1;
        req.ray_cos     = '0;
        req.ray_sin     = '0;
        req.player_x    = '0;
        req.player_y    = '0;
        pix.ready       = 1'b0;
        send_idle       = 0;
        recv_stall      = 0;
        hold_off        = 1'b0;
        rst_n           = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // absent textures: fallbacks, sky, horizon, zero height
        send_word(1'b1, SURF_WALL, 300, 5, 0, 100, 400, 300, 0, 0, 0, 0);
        send_word(1'b1, SURF_DOOR, 300, 5, 0, 100, 400, 300, 0, 0, 0, 0);
        send_word(1'b1, SURF_NONE, 50, 1023, 0, 100, 400, 300, 0, 0, 0, 0);
        send_word(1'b1, SURF_WALL, 200, 0, 0, 100, 150, 300, 0, 0, 0, 0);
        send_word(1'b1, SURF_WALL, 500, 7, 0, 100, 150, 300, 16384, 16384, 0, 0);
        send_word(1'b1, SURF_WALL, 300, 7, 0, 100, 400, 0, 0, 0, 0, 0);
        send_word(1'b1, SURF_DOOR, 300, 7, 0, 100, 400, 0, 0, 0, 0, 0);
        send_word(1'b1, SURF_WALL, 300, 9, 0, 300, 100, 50, 0, 0, 0, 0);
        // ignored loads
        load_tex(SURF_WALL, 64, 0, 32'hDEADBEEF);
        load_tex(SURF_DOOR, 0, 1023, 32'hDEADBEEF);
        load_tex(SURF_NONE, 0, 0, 32'hDEADBEEF);
        load_tex(SURF_WALL, 511, 1023, 32'hFFFFFFFF);
        drain();

        fill_tex(SURF_WALL);
        fill_tex(SURF_DOOR);
        fill_tex(SURF_FLOOR);
        drain();

        // textured extremes
        send_word(1'b1, SURF_WALL, 0, 0, 0, -32768, 32767, 65535, 0, 0, 0, 0);
        send_word(1'b1, SURF_WALL, 511, 1023, 0, -32768, 32767, 1, 0, 0, 0, 0);
        send_word(1'b1, SURF_DOOR, 256, 63, 0, 256, 400, 64, 0, 0, 0, 0);
        send_word(1'b1, SURF_DOOR, 511, 64, 0, 0, 511, 512, 0, 0, 0, 0);
        send_word(1'b1, SURF_WALL, 511, 3, 0, 0, 10, 20, 16384, -16384, 32'sh7FFFFFFF,
                  32'sh80000000);
        send_word(1'b1, SURF_WALL, 257, 3, 0, 0, 10, 20, -16384, 16384, 32'h00200000,
                  32'h00200000);
        send_word(1'b1, SURF_WALL, 511, 3, 0, 0, 10, 20, 16384, 16384, 32'h00010000,
                  32'h00010000);
        send_word(1'b1, SURF_WALL, 400, 3, 0, 0, 10, 20, 0, 0, -1, 32'h00100000);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 77; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 77; end
                default: begin send_idle = 11; recv_stall = 11; end
            endcase
            for (int i = 0; i < 300; i++)
            begin
                if ($urandom_range(9) == 0)
                    load_tex(2'($urandom()), $urandom_range(70), $urandom_range(70), $urandom());
                else
                    rand_render($urandom_range(4) == 0);
            end
            if (ph == 0)
            begin
                hold_off = 1'b1;
                fork
                    begin
                        repeat (200) @(posedge clk);
                        hold_off = 1'b0;
                    end
                    for (int i = 0; i < 60; i++)
                        rand_render(1'b0);
                join
            end
            drain();
        end

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
